### sv/ppc_pkg.sv
// ----------------------------------------------------------------------------
// ppc_pkg
// Shared types and constants of the positional popcount core.
// ----------------------------------------------------------------------------
package ppc_pkg;

    localparam int WORD_BITS  = 64;
    localparam int BYTES      = WORD_BITS / 8;
    localparam int POS_BITS   = 6;
    localparam int CNT_OUT_W  = 64;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    // element width codes
    localparam logic [1:0] MODE_8  = 2'd0;
    localparam logic [1:0] MODE_16 = 2'd1;
    localparam logic [1:0] MODE_32 = 2'd2;
    localparam logic [1:0] MODE_64 = 2'd3;

    // register indexes
    localparam logic REG_WIDTH_MODE = 1'b0;

    typedef struct packed {
        logic       load;
        logic [1:0] mode;
    } ppc_snap_ctl_t;

endpackage

### sv/ppc_word_if.sv
// ----------------------------------------------------------------------------
// ppc_word_if
// Input word channel: data word, byte-valid mask and last flag.
// ----------------------------------------------------------------------------
interface ppc_word_if import ppc_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] data_word;
    logic [BYTES-1:0]     byte_valid;
    logic                 last_item;

    modport source (output valid, data_word, byte_valid, last_item, input ready);
    modport sink   (input valid, data_word, byte_valid, last_item, output ready);

endinterface

### sv/ppc_count_if.sv
// ----------------------------------------------------------------------------
// ppc_count_if
// Result channel: one folded count per element bit position.
// ----------------------------------------------------------------------------
interface ppc_count_if import ppc_pkg::*; ();

    logic                 valid;
    logic                 ready;
    logic [POS_BITS-1:0]  bit_position;
    logic [CNT_OUT_W-1:0] bit_count;
    logic                 last_of_run;

    modport source (output valid, bit_position, bit_count, last_of_run, input ready);
    modport sink   (input valid, bit_position, bit_count, last_of_run, output ready);

endinterface

### sv/ppc_apb_regs.sv
// ----------------------------------------------------------------------------
// ppc_apb_regs
// APB configuration register holding the element width mode.
// ----------------------------------------------------------------------------
module ppc_apb_regs import ppc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [1:0]            width_mode
);

    logic [1:0] mode_reg;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_WIDTH_MODE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_64;
        end
        else if (wr_en)
        begin
            mode_reg <= pwdata[1:0];
        end
    end

    // low address bits are ignored: any address with bit 2 clear reads the mode register
    always_comb
    begin
        prdata = '0;
        if (paddr[2] == REG_WIDTH_MODE && paddr[1:0] == 2'b00)
        begin
            prdata = APB_DATA_W'(mode_reg);
        end
        else if (paddr[2] == REG_WIDTH_MODE)
        begin
            prdata = APB_DATA_W'(mode_reg);
        end
    end

    assign width_mode = mode_reg;

endmodule

### sv/ppc_accum.sv
// ----------------------------------------------------------------------------
// ppc_accum
// Input register and the 64 per-bit running totals.
// ----------------------------------------------------------------------------
module ppc_accum import ppc_pkg::*;
#(
    parameter int COUNT_BITS = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    ppc_word_if.sink              word,
    input  logic [1:0]            width_mode,
    input  logic                  fold_busy,
    output ppc_snap_ctl_t         snap_ctl,
    output logic [COUNT_BITS-1:0] snap_totals [WORD_BITS]
);

    logic [WORD_BITS-1:0]  byte_mask;
    logic [WORD_BITS-1:0]  bits_reg;
    logic                  last_reg;
    logic                  vld_reg;
    logic                  advance;
    logic [COUNT_BITS-1:0] totals_reg [WORD_BITS];
    logic [COUNT_BITS-1:0] sum_next   [WORD_BITS];

    always_comb
    begin
        for (int k = 0; k < BYTES; k++)
        begin
            byte_mask[8*k +: 8] = {8{word.byte_valid[k]}};
        end
    end

    // a last word waits here until the fold unit has finished the previous run
    assign advance    = vld_reg && (!last_reg || !fold_busy);
    assign word.ready = !vld_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (word.ready)
        begin
            vld_reg <= word.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (word.valid && word.ready)
        begin
            bits_reg <= word.data_word & byte_mask;
            last_reg <= word.last_item;
        end
    end

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            sum_next[b] = totals_reg[b] + COUNT_BITS'(bits_reg[b]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int b = 0; b < WORD_BITS; b++)
            begin
                totals_reg[b] <= '0;
            end
        end
        else if (advance)
        begin
            for (int b = 0; b < WORD_BITS; b++)
            begin
                totals_reg[b] <= last_reg ? '0 : sum_next[b];
            end
        end
    end

    assign snap_ctl.load = advance && last_reg;
    assign snap_ctl.mode = width_mode;
    assign snap_totals   = sum_next;

endmodule

### sv/ppc_fold.sv
// ----------------------------------------------------------------------------
// ppc_fold
// Snapshot of the totals, in-place fold by halves, and serial result output.
// ----------------------------------------------------------------------------
module ppc_fold import ppc_pkg::*;
#(
    parameter int COUNT_BITS = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ppc_snap_ctl_t         snap_ctl,
    input  logic [COUNT_BITS-1:0] snap_totals [WORD_BITS],
    output logic                  fold_busy,
    ppc_count_if.source           count
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_FOLD = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]            state_reg;
    logic [1:0]            state_next;
    logic [1:0]            lvl_reg;
    logic [1:0]            lvl_next;
    logic [1:0]            mode_reg;
    logic [POS_BITS-1:0]   pos_reg;
    logic [POS_BITS-1:0]   last_pos;
    logic [COUNT_BITS-1:0] snap_reg [WORD_BITS];

    logic                  out_vld_reg;
    logic [POS_BITS-1:0]   out_pos_reg;
    logic [COUNT_BITS-1:0] out_cnt_reg;
    logic                  out_last_reg;
    logic                  out_load;

    always_comb
    begin
        case (mode_reg)
            MODE_8:  last_pos = POS_BITS'(7);
            MODE_16: last_pos = POS_BITS'(15);
            MODE_32: last_pos = POS_BITS'(31);
            default: last_pos = POS_BITS'(63);
        endcase
    end

    assign lvl_next  = lvl_reg - 2'd1;
    assign out_load  = (state_reg == ST_EMIT) && (!out_vld_reg || count.ready);
    assign fold_busy = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (snap_ctl.load)
                begin
                    state_next = (snap_ctl.mode == MODE_64) ? ST_EMIT : ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                if (lvl_next == mode_reg)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_load && pos_reg == last_pos)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            lvl_reg   <= MODE_64;
            mode_reg  <= MODE_64;
            pos_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_IDLE && snap_ctl.load)
            begin
                lvl_reg  <= MODE_64;
                mode_reg <= snap_ctl.mode;
                pos_reg  <= '0;
            end
            else if (state_reg == ST_FOLD)
            begin
                lvl_reg <= lvl_next;
            end
            else if (out_load)
            begin
                pos_reg <= pos_reg + POS_BITS'(1);
            end
        end
    end

    // fold upper half of the current span onto the lower half, then shift out
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && snap_ctl.load)
        begin
            snap_reg <= snap_totals;
        end
        else if (state_reg == ST_FOLD)
        begin
            for (int i = 0; i < WORD_BITS / 2; i++)
            begin
                if (lvl_reg == MODE_64)
                begin
                    snap_reg[i] <= snap_reg[i] + snap_reg[i + 32];
                end
                else if (lvl_reg == MODE_32 && i < 16)
                begin
                    snap_reg[i] <= snap_reg[i] + snap_reg[i + 16];
                end
                else if (lvl_reg == MODE_16 && i < 8)
                begin
                    snap_reg[i] <= snap_reg[i] + snap_reg[i + 8];
                end
            end
        end
        else if (out_load)
        begin
            for (int i = 0; i < WORD_BITS - 1; i++)
            begin
                snap_reg[i] <= snap_reg[i + 1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (count.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_pos_reg  <= pos_reg;
            out_cnt_reg  <= snap_reg[0];
            out_last_reg <= (pos_reg == last_pos);
        end
    end

    assign count.valid        = out_vld_reg;
    assign count.bit_position = out_pos_reg;
    assign count.bit_count    = CNT_OUT_W'(out_cnt_reg);
    assign count.last_of_run  = out_last_reg;

endmodule

### sv/positional_popcount_core.sv
// ----------------------------------------------------------------------------
// positional_popcount_core
// Per-bit population count over a stream of masked 64-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   word  : valid/ready channel of data_word, byte_valid and last_item. A transfer
//           with last_item set closes the run.
//   count : valid/ready channel, one transfer per element bit position, in
//           increasing order, last_of_run on the final one of the run.
//   APB   : element_width_mode at address 0 (0=8, 1=16, 2=32, 3=64 bit elements),
//           written only while the core is idle.
// Timing:
//   one word per cycle is taken while no last word is held. A last word waits in
//   the input register until the fold unit is idle; the fold unit then snapshots
//   the totals, halves the 64-bit span down to the element width and delivers one
//   result per cycle while the count channel is ready. Only a second last word
//   waits on a run in progress; plain words still flow into the totals meanwhile.
// Reset: totals clear to zero, mode returns to 64-bit elements, both channels empty.
// Stall: a stalled count channel holds its output register and freezes the run;
//   the word channel backs up only once a further last word is waiting.
// ----------------------------------------------------------------------------
module positional_popcount_core import ppc_pkg::*;
#(
    parameter int COUNT_BITS = 64
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    ppc_word_if.sink              word,
    ppc_count_if.source           count
);

    logic                  [1:0] width_mode;
    logic                        fold_busy;
    ppc_snap_ctl_t               snap_ctl;
    logic [COUNT_BITS-1:0]       snap_totals [WORD_BITS];

    ppc_apb_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .width_mode (width_mode)
    );

    ppc_accum #(.COUNT_BITS(COUNT_BITS)) u_accum (
        .clk         (clk),
        .rst_n       (rst_n),
        .word        (word),
        .width_mode  (width_mode),
        .fold_busy   (fold_busy),
        .snap_ctl    (snap_ctl),
        .snap_totals (snap_totals)
    );

    ppc_fold #(.COUNT_BITS(COUNT_BITS)) u_fold (
        .clk         (clk),
        .rst_n       (rst_n),
        .snap_ctl    (snap_ctl),
        .snap_totals (snap_totals),
        .fold_busy   (fold_busy),
        .count       (count)
    );

endmodule
